// ===== hw/rtl/mos_pkg.sv =====
// Shared types, constants and piece tables of the move ordering scorer.
package mos_pkg;

    localparam int PLY_LIMIT     = 64;
    localparam int HISTORY_BITS  = 24;
    localparam int BOARD_SQUARES = 64;

    localparam int SQ_W       = $clog2(BOARD_SQUARES);
    localparam int MOVE_W     = 2 * SQ_W;
    localparam int HIST_DEPTH = BOARD_SQUARES * BOARD_SQUARES;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int KILL_AW    = $clog2(PLY_LIMIT);
    localparam int PIECE_W    = 3;
    localparam int PLY_W      = 6;
    localparam int DEPTH_W    = 6;
    localparam int DSQ_W      = 2 * DEPTH_W;
    localparam int SCORE_W    = 24;
    localparam int KIND_W     = 2;
    localparam int SRC_W      = 2;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    localparam logic [SCORE_W-1:0] SCORE_MAX       = {SCORE_W{1'b1}};
    localparam logic [SCORE_W-1:0] KILLER1_SCORE   = 24'd90000;
    localparam logic [SCORE_W-1:0] KILLER2_SCORE   = 24'd80000;
    localparam logic [SCORE_W-1:0] CAPTURE_BONUS   = 24'd100000;
    localparam logic [SCORE_W-1:0] QUIESCE_BONUS   = 24'd10000;
    localparam logic [SCORE_W-1:0] CAPTURE_MIN     = 24'd9100;
    localparam logic [SCORE_W-1:0] CAPTURE_MAX     = 24'd190000;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SCORE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECORD = 2'd2;

    localparam logic [SRC_W-1:0] SRC_CAPTURE = 2'd0;
    localparam logic [SRC_W-1:0] SRC_KILLER1 = 2'd1;
    localparam logic [SRC_W-1:0] SRC_KILLER2 = 2'd2;
    localparam logic [SRC_W-1:0] SRC_HISTORY = 2'd3;

    localparam logic [PIECE_W-1:0] PIECE_EMPTY = 3'd0;

    typedef struct packed {
        logic                 pad;
        logic                 quiescence_mode;
        logic [DEPTH_W-1:0]   search_depth;
        logic [PLY_W-1:0]     ply_index;
        logic [PIECE_W-1:0]   attacker_piece;
        logic [PIECE_W-1:0]   victim_piece;
        logic [SQ_W-1:0]      to_square;
        logic [SQ_W-1:0]      from_square;
    } t_in_data;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear_start;
        logic sweep;
        logic record_write;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_clear;
        logic in_access;
        logic is_score;
        logic out_free;
        logic sweep_done;
    } t_status;

    // Victim value times 100.
    function automatic logic [SCORE_W-1:0] victim_score(input logic [PIECE_W-1:0] piece);
        logic [SCORE_W-1:0] v;
        case (piece)
            3'd1:    v = 24'd10000;
            3'd2:    v = 24'd32000;
            3'd3:    v = 24'd33000;
            3'd4:    v = 24'd50000;
            3'd5:    v = 24'd90000;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [SCORE_W-1:0] attacker_worth(input logic [PIECE_W-1:0] piece);
        logic [SCORE_W-1:0] v;
        case (piece)
            3'd1:    v = 24'd100;
            3'd2:    v = 24'd320;
            3'd3:    v = 24'd330;
            3'd4:    v = 24'd500;
            3'd5:    v = 24'd900;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/mos_ctrl.sv =====
// Controller state machine of the move ordering scorer.
module mos_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mos_pkg::t_status i_status,
    output mos_pkg::t_cmd    o_cmd
);
    import mos_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.sweep_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_status.in_clear) begin
                        n_state = ST_CLEAR;
                    end else if (i_status.in_access) begin
                        n_state = ST_ACCESS;
                    end
                end
            end
            ST_ACCESS: begin
                if (!i_status.is_score || i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.sweep = 1'b1;
            end
            ST_IDLE: begin
                o_ready           = 1'b1;
                o_cmd.capture     = i_valid;
                o_cmd.clear_start = i_valid && i_status.in_clear;
            end
            ST_ACCESS: begin
                o_cmd.record_write = !i_status.is_score;
                o_cmd.load_out     = i_status.is_score && i_status.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/mos_datapath.sv =====
// Datapath of the move ordering scorer: killer and history stores and scoring.
module mos_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [mos_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic [mos_pkg::KIND_W-1:0]         i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mos_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic [mos_pkg::SRC_W-1:0]          o_m_tuser,
    input  mos_pkg::t_cmd                      i_cmd,
    output mos_pkg::t_status                   o_status
);
    import mos_pkg::*;

    t_in_data in_d;

    logic [KIND_W-1:0]   r_kind;
    logic [MOVE_W-1:0]   r_move;
    logic [PIECE_W-1:0]  r_victim;
    logic [PIECE_W-1:0]  r_attacker;
    logic [PLY_W-1:0]    r_ply;
    logic [DSQ_W-1:0]    r_dsq;
    logic                r_qmode;

    logic [MOVE_W-1:0]   kf_mem [PLY_LIMIT];
    logic [MOVE_W-1:0]   ks_mem [PLY_LIMIT];
    logic [HISTORY_BITS-1:0] hist_mem [HIST_DEPTH];
    logic [MOVE_W-1:0]   r_kf_rd;
    logic [MOVE_W-1:0]   r_ks_rd;
    logic [HISTORY_BITS-1:0] r_hist_rd;
    logic [PLY_LIMIT-1:0] r_kf_valid;
    logic [PLY_LIMIT-1:0] r_ks_valid;
    logic [HIST_AW-1:0]  r_clr_ptr;

    logic                r_out_valid;
    logic [SCORE_W-1:0]  r_out_score;
    logic [SRC_W-1:0]    r_out_src;

    logic [MOVE_W-1:0]   in_move;
    logic [KILL_AW-1:0]  rd_kidx;
    logic [HIST_AW-1:0]  rd_hidx;
    logic [KILL_AW-1:0]  kidx;
    logic                ply_ok;
    logic                kf_hit;
    logic                ks_hit;
    logic                killer_upd;
    logic                hist_we;
    logic [HIST_AW-1:0]  hist_waddr;
    logic [HISTORY_BITS-1:0] hist_wdata;
    logic [HISTORY_BITS:0]   hist_sum;
    logic [SCORE_W-1:0]  score;
    logic [SRC_W-1:0]    src;

    assign in_d    = t_in_data'(i_s_tdata);
    assign in_move = {in_d.from_square, in_d.to_square};

    assign o_status.in_clear   = (i_s_tuser == KIND_CLEAR);
    assign o_status.in_access  = (i_s_tuser == KIND_SCORE) ||
                                 (i_s_tuser == KIND_RECORD && in_d.victim_piece == PIECE_EMPTY);
    assign o_status.is_score   = (r_kind == KIND_SCORE);
    assign o_status.out_free   = !r_out_valid || i_m_tready;
    assign o_status.sweep_done = (r_clr_ptr == HIST_AW'(HIST_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind     <= i_s_tuser;
            r_move     <= in_move;
            r_victim   <= in_d.victim_piece;
            r_attacker <= in_d.attacker_piece;
            r_ply      <= in_d.ply_index;
            r_dsq      <= DSQ_W'(in_d.search_depth * in_d.search_depth);
            r_qmode    <= in_d.quiescence_mode;
        end
    end

    assign rd_kidx = i_cmd.capture ? KILL_AW'(in_d.ply_index) : KILL_AW'(r_ply);
    assign rd_hidx = i_cmd.capture ? HIST_AW'(in_move) : HIST_AW'(r_move);
    assign kidx    = KILL_AW'(r_ply);
    assign ply_ok  = (32'(r_ply) < PLY_LIMIT);

    assign kf_hit     = ply_ok && r_kf_valid[kidx] && (r_kf_rd == r_move);
    assign ks_hit     = ply_ok && r_ks_valid[kidx] && (r_ks_rd == r_move);
    assign killer_upd = i_cmd.record_write && ply_ok && !kf_hit && !ks_hit;

    always_ff @(posedge i_clk) begin
        if (killer_upd) begin
            kf_mem[kidx] <= r_move;
            ks_mem[kidx] <= r_kf_rd;
        end
        r_kf_rd <= kf_mem[rd_kidx];
        r_ks_rd <= ks_mem[rd_kidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_start) begin
            r_kf_valid <= '0;
            r_ks_valid <= '0;
        end else if (killer_upd) begin
            r_kf_valid[kidx] <= 1'b1;
            r_ks_valid[kidx] <= r_kf_valid[kidx];
        end
    end

    assign hist_sum   = {1'b0, r_hist_rd} + (HISTORY_BITS + 1)'(r_dsq);
    assign hist_we    = i_cmd.sweep || i_cmd.record_write;
    assign hist_waddr = i_cmd.sweep ? r_clr_ptr : HIST_AW'(r_move);
    always_comb begin
        if (i_cmd.sweep) begin
            hist_wdata = '0;
        end else if (hist_sum[HISTORY_BITS]) begin
            hist_wdata = {HISTORY_BITS{1'b1}};
        end else begin
            hist_wdata = hist_sum[HISTORY_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        r_hist_rd <= hist_mem[rd_hidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_start) begin
            r_clr_ptr <= '0;
        end else if (i_cmd.sweep && !o_status.sweep_done) begin
            r_clr_ptr <= r_clr_ptr + HIST_AW'(1);
        end
    end

    always_comb begin
        if (r_victim != PIECE_EMPTY) begin
            score = victim_score(r_victim) - attacker_worth(r_attacker) +
                    (r_qmode ? QUIESCE_BONUS : CAPTURE_BONUS);
            src   = SRC_CAPTURE;
        end else if (kf_hit) begin
            score = KILLER1_SCORE;
            src   = SRC_KILLER1;
        end else if (ks_hit) begin
            score = KILLER2_SCORE;
            src   = SRC_KILLER2;
        end else begin
            score = (32'(r_hist_rd) > 32'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(r_hist_rd);
            src   = SRC_HISTORY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_score <= score;
            r_out_src   <= src;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_score;
    assign o_m_tuser  = r_out_src;

endmodule

// ===== hw/rtl/move_ordering_scorer.sv =====
// Top level of the move ordering scorer: controller and datapath.
// A score item and a quiet-cutoff record item each pass an accept cycle, which
// issues one read of the killer and history memories, and an access cycle,
// which loads the result register or writes the updated killers and history
// count back, so one item is in work at a time. A score item also waits in the
// access cycle while the output register still holds an untaken result. An item
// of the unused kind, or a record item that names a captured piece, needs only
// its accept cycle. A clear item and every reset start a sweep of the
// 4096-entry history memory, one entry per cycle, during which no transaction
// is accepted.
module move_ordering_scorer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // from_square, to_square, victim_piece, attacker_piece, ply_index,
    // search_depth, quiescence_mode, one zero pad bit.
    input  logic [mos_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // kind.
    input  logic [mos_pkg::KIND_W-1:0]       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // move_score.
    output logic [mos_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // score_source.
    output logic [mos_pkg::SRC_W-1:0]        o_m_tuser
);
    import mos_pkg::*;

    t_cmd    cmd;
    t_status status;

    mos_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mos_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule

// ===== hw/rtl/mos_checker.sv =====
// Port-level assertion checker of the move ordering scorer and its bind.
module mos_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [mos_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input logic [mos_pkg::KIND_W-1:0]       i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [mos_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input logic [mos_pkg::SRC_W-1:0]        o_m_tuser
);
    import mos_pkg::*;

    logic in_acc;
    assign in_acc = i_s_tvalid && o_s_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output transaction changed while stalled");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_s_tuser == KIND_CLEAR |=> !o_s_tready)
        else $error("clear transaction did not start the history sweep");

    a_access_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_s_tuser == KIND_SCORE ||
                   (i_s_tuser == KIND_RECORD && i_s_tdata[14:12] == PIECE_EMPTY))
        |=> !o_s_tready)
        else $error("memory access cycle skipped");

    a_killer1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == SRC_KILLER1 |-> o_m_tdata == KILLER1_SCORE)
        else $error("first killer score wrong");

    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == SRC_CAPTURE |->
        o_m_tdata >= CAPTURE_MIN && o_m_tdata <= CAPTURE_MAX)
        else $error("capture score out of range");

endmodule

bind move_ordering_scorer mos_checker u_mos_checker (.*);
